FILE: src/lsd_pkg.sv
// Package for the decimal LSD radix sorter: widths, constants, digit helpers.
// No dependencies.
package lsd_pkg;

    localparam int VAL_W      = 30;
    localparam int DIG_W      = 4;
    localparam int MAX_ITEMS  = 64;
    localparam int RADIX      = 10;
    localparam int DIG_MAX    = 9;
    localparam logic [DIG_W-1:0] NUM_DIGITS_RST = 4'd3;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } item_t;

    function automatic logic [VAL_W-1:0] pow_ten(input logic [DIG_W-1:0] p);
        logic [VAL_W-1:0] r;
        begin
            case (p)
                4'd0: r = 30'd1;
                4'd1: r = 30'd10;
                4'd2: r = 30'd100;
                4'd3: r = 30'd1000;
                4'd4: r = 30'd10000;
                4'd5: r = 30'd100000;
                4'd6: r = 30'd1000000;
                4'd7: r = 30'd10000000;
                4'd8: r = 30'd100000000;
                4'd9: r = 30'd1000000000;
                default: r = 30'd1;
            endcase
            return r;
        end
    endfunction

    function automatic logic [DIG_W-1:0] eff_digits(input logic [DIG_W-1:0] d);
        logic [DIG_W-1:0] r;
        begin
            r = d;
            if (d == 4'd0)
                r = 4'd1;
            else if (d > DIG_W'(DIG_MAX))
                r = DIG_W'(DIG_MAX);
            return r;
        end
    endfunction

endpackage

FILE: src/lsd_front.sv
// Front end: accepts items, clamps values, pushes them into a small queue.
// Depends on lsd_pkg.
module lsd_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lsd_pkg::VAL_W-1:0]    value,
    input  logic                         last_item,
    input  logic [lsd_pkg::DIG_W-1:0]    num_digits,
    output logic                         busy,
    output logic                         q_valid,
    output lsd_pkg::item_t               q_item,
    input  logic                         q_pop
);

    localparam int QD = 2;

    lsd_pkg::item_t   q_reg [QD];
    logic [1:0]       cnt_reg, cnt_next;
    logic             wp_reg, rp_reg;
    logic             push;
    logic             closed_reg, closed_next;
    logic [lsd_pkg::VAL_W-1:0] maxv, clamped;

    assign maxv    = lsd_pkg::pow_ten(lsd_pkg::eff_digits(num_digits)) - 30'd1;
    assign clamped = (value > maxv) ? maxv : value;

    // after the closing beat, hold off until the back end pops it; also hold off while the queue is full
    assign busy    = closed_reg || (cnt_reg == 2'(QD));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
        closed_next = closed_reg;
        if (push && last_item)
            closed_next = 1'b1;
        else if (q_pop && q_item.last)
            closed_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wp_reg     <= 1'b0;
            rp_reg     <= 1'b0;
            closed_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            closed_reg <= closed_next;
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= '{value: clamped, last: last_item};
    end

endmodule

FILE: src/lsd_back.sv
// Back end: stores the set, runs count / prefix / scatter / copy per digit, emits.
// Depends on lsd_pkg.
module lsd_back
#(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  lsd_pkg::item_t               q_item,
    output logic                         q_pop,
    input  logic [lsd_pkg::DIG_W-1:0]    num_digits,
    output logic                         out_valid,
    output logic [lsd_pkg::VAL_W-1:0]    sorted_value,
    output logic                         last_out
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int VW = lsd_pkg::VAL_W;
    localparam int PW = VW + 32;
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_CNT   = 8'b0000_0010,
        S_DIG   = 8'b0000_0100,
        S_PRE   = 8'b0000_1000,
        S_SCAT  = 8'b0001_0000,
        S_COPY  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_WAIT  = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [VW-1:0] item_mem [MAX_ITEMS];
    logic [VW-1:0] scat_mem [MAX_ITEMS];
    logic [CW-1:0] cnt_reg [lsd_pkg::RADIX];
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [3:0]    k_reg;
    logic [lsd_pkg::DIG_W-1:0] pass_reg, dmax_reg;
    logic [VW-1:0] rd_reg, srd_reg;
    logic          rd_ok_reg;
    logic [AW-1:0] rd_addr, srd_addr;
    logic [CW-1:0] pos;

    logic [VW-1:0] dv_num_reg, dv_prev_reg, dv_val_reg;
    logic [3:0]    dv_k_reg;
    logic [3:0]    dig_reg;
    logic [PW-1:0] dv_prod;
    logic [VW-1:0] dv_quot, dv_tens, dv_diff;

    // x / 10 as (x * 0xCCCCCCCD) >> 35, exact for any 30-bit x
    assign dv_prod = PW'(dv_num_reg) * PW'(RECIP_10);
    assign dv_quot = {3'b000, dv_prod[PW-1:35]};
    assign dv_tens = {dv_num_reg[VW-4:0], 3'b000} + {dv_num_reg[VW-2:0], 1'b0};
    assign dv_diff = dv_prev_reg - dv_tens;

    assign pos      = cnt_reg[dig_reg] - CW'(1);
    assign rd_addr  = (state_reg == S_SCAT) ? AW'(i_reg - CW'(1)) : i_reg[AW-1:0];
    assign srd_addr = (state_reg == S_COPY && i_reg != n_reg)
                      ? AW'(i_reg + CW'(1)) : i_reg[AW-1:0];

    assign q_pop = (state_reg == S_LOAD) && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            n_reg       <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
            pass_reg    <= '0;
            dmax_reg    <= '0;
            dv_k_reg    <= '0;
            rd_ok_reg   <= 1'b0;
            out_valid   <= 1'b0;
            last_out    <= 1'b0;
            for (int j = 0; j < lsd_pkg::RADIX; j++)
                cnt_reg[j] <= '0;
        end
        else
        begin
            out_valid <= (state_reg == S_OUT) && rd_ok_reg;
            case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (n_reg != CW'(MAX_ITEMS))
                            n_reg <= n_reg + CW'(1);
                        if (q_item.last)
                        begin
                            dmax_reg  <= lsd_pkg::eff_digits(num_digits);
                            pass_reg  <= '0;
                            i_reg     <= '0;
                            rd_ok_reg <= 1'b0;
                            for (int j = 0; j < lsd_pkg::RADIX; j++)
                                cnt_reg[j] <= '0;
                            state_reg <= S_CNT;
                        end
                    end
                end
                S_CNT:
                begin
                    // fetch item i (registered read), then extract digit
                    if (!rd_ok_reg)
                    begin
                        if (i_reg == n_reg)
                        begin
                            k_reg     <= 4'd1;
                            state_reg <= S_PRE;
                        end
                        else
                            rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        dv_k_reg  <= '0;
                        state_reg <= S_DIG;
                    end
                end
                S_DIG:
                begin
                    if (dv_k_reg == pass_reg + 4'd2)
                    begin
                        rd_ok_reg <= 1'b0;
                        if (k_reg == 4'd0)
                        begin
                            cnt_reg[dig_reg] <= cnt_reg[dig_reg] + CW'(1);
                            i_reg            <= i_reg + CW'(1);
                            state_reg        <= S_CNT;
                        end
                        else
                        begin
                            cnt_reg[dig_reg] <= pos;
                            state_reg        <= S_SCAT;
                        end
                    end
                    else
                        dv_k_reg <= dv_k_reg + 4'd1;
                end
                S_PRE:
                begin
                    cnt_reg[k_reg] <= cnt_reg[k_reg] + cnt_reg[k_reg - 4'd1];
                    if (k_reg == 4'(lsd_pkg::RADIX - 1))
                    begin
                        i_reg     <= n_reg;
                        rd_ok_reg <= 1'b0;
                        state_reg <= S_SCAT;
                    end
                    else
                        k_reg <= k_reg + 4'd1;
                end
                S_SCAT:
                begin
                    // k_reg nonzero marks scatter mode for S_DIG
                    if (!rd_ok_reg)
                    begin
                        if (i_reg == '0)
                        begin
                            k_reg     <= 4'd0;
                            state_reg <= S_COPY;
                        end
                        else
                        begin
                            i_reg     <= i_reg - CW'(1);
                            rd_ok_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        dv_k_reg  <= '0;
                        state_reg <= S_DIG;
                    end
                end
                S_COPY:
                begin
                    if (i_reg == n_reg)
                    begin
                        i_reg <= '0;
                        if (pass_reg + 4'd1 == dmax_reg)
                        begin
                            pass_reg  <= '0;
                            rd_ok_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pass_reg  <= pass_reg + 4'd1;
                            for (int j = 0; j < lsd_pkg::RADIX; j++)
                                cnt_reg[j] <= '0;
                            state_reg <= S_CNT;
                        end
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end
                S_OUT:
                begin
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        last_out     <= (i_reg + CW'(1) == n_reg);
                        rd_ok_reg    <= 1'b0;
                        if (i_reg + CW'(1) == n_reg)
                            state_reg <= S_WAIT;
                        else
                            i_reg <= i_reg + CW'(1);
                    end
                end
                S_WAIT:
                begin
                    n_reg     <= '0;
                    state_reg <= S_LOAD;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // memories, registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && q_valid && n_reg != CW'(MAX_ITEMS))
            item_mem[n_reg[AW-1:0]] <= q_item.value;
        else if (state_reg == S_COPY && i_reg != n_reg)
            item_mem[i_reg[AW-1:0]] <= srd_reg;
        rd_reg  <= item_mem[rd_addr];
        srd_reg <= scat_mem[srd_addr];
        if (state_reg == S_DIG && dv_k_reg == pass_reg + 4'd2 && k_reg != 4'd0)
            scat_mem[pos[AW-1:0]] <= dv_val_reg;
        if (state_reg == S_OUT && !rd_ok_reg)
            sorted_value <= item_mem[i_reg[AW-1:0]];
    end

    // digit unit: pass+1 divide-by-ten steps, then digit = prev - 10 * quotient
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CNT || state_reg == S_SCAT) && rd_ok_reg)
        begin
            dv_num_reg <= rd_reg;
            dv_val_reg <= rd_reg;
        end
        else if (state_reg == S_DIG && dv_k_reg <= pass_reg)
        begin
            dv_prev_reg <= dv_num_reg;
            dv_num_reg  <= dv_quot;
        end
        dig_reg <= dv_diff[3:0];
    end

endmodule

FILE: src/lsd_decimal_radix_sort_top.sv
// Channel   | Dir | Handshake            | Payload
// item      | in  | start / busy         | value[29:0], last_item
// result    | out | done (strobe)        | sorted_value[29:0], last_out
// config    | in  | cfg_valid/cfg_ready  | cfg_data[3:0] (num_digits)
// Loading: one beat per cycle while busy is low. After the closing beat, each digit pass
// over the n items counts, prefix-sums, scatters and copies, using the iterative
// divide-by-ten digit unit; results are then emitted and the back end returns to loading.
// Reset is asynchronous; busy is high while a closing beat waits in the 2-entry queue or
// the queue is full, so during a sort up to two beats of the next set are taken.
// Depends on lsd_pkg, lsd_front, lsd_back.
module lsd_decimal_radix_sort_top
#(
    parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lsd_pkg::VAL_W-1:0]    value,
    input  logic                         last_item,
    output logic                         done,
    output logic [lsd_pkg::VAL_W-1:0]    sorted_value,
    output logic                         last_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lsd_pkg::DIG_W-1:0]    cfg_data
);

    logic [lsd_pkg::DIG_W-1:0] nd_reg;
    logic                      q_valid, q_pop;
    lsd_pkg::item_t            q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nd_reg <= lsd_pkg::NUM_DIGITS_RST;
        else if (cfg_valid)
            nd_reg <= cfg_data;
    end

    lsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .last_item  (last_item),
        .num_digits (nd_reg),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    lsd_back #(.MAX_ITEMS(MAX_ITEMS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .num_digits   (nd_reg),
        .out_valid    (done),
        .sorted_value (sorted_value),
        .last_out     (last_out)
    );

endmodule
